// ===== hdl/aes_ke_pkg.sv =====
// Shared types, constants and the S-box table for the AES-128 key expansion.
package aes_ke_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned IdxW   = 6;
  localparam logic [IdxW-1:0] LastIdx = 6'd43;
  localparam logic [7:0] RconFirst = 8'h01;
  localparam logic [7:0] XtimePoly = 8'h1b;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic       sub_en;
    logic [7:0] rcon;
  } word_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? XtimePoly : 8'h00);
  endfunction

endpackage

// ===== hdl/aes_ke_if.sv =====
// Valid/ready channel interfaces for key requests and schedule words.
interface aes_ke_key_if;
  logic                 valid;
  logic                 ready;
  aes_ke_pkg::word_t    key_word_0;
  aes_ke_pkg::word_t    key_word_1;
  aes_ke_pkg::word_t    key_word_2;
  aes_ke_pkg::word_t    key_word_3;

  modport source (output valid, key_word_0, key_word_1, key_word_2, key_word_3,
                  input ready);
  modport sink (input valid, key_word_0, key_word_1, key_word_2, key_word_3,
                output ready);
endinterface

interface aes_ke_word_if;
  logic                             valid;
  logic                             ready;
  logic [aes_ke_pkg::IdxW-1:0]      word_index;
  aes_ke_pkg::word_t                schedule_word;
  logic                             last_word;

  modport source (output valid, word_index, schedule_word, last_word, input ready);
  modport sink (input valid, word_index, schedule_word, last_word, output ready);
endinterface

// ===== hdl/aes_ke_word_unit.sv =====
// Shared word unit: XOR with the word four back, after RotWord, SubWord and Rcon when sub_en is set.
module aes_ke_word_unit (
  input  aes_ke_pkg::word_t     w_back_i,
  input  aes_ke_pkg::word_t     w_prev_i,
  input  aes_ke_pkg::word_ctl_t ctl_i,
  output aes_ke_pkg::word_t     w_new_o
);

  aes_ke_pkg::word_t rot;
  aes_ke_pkg::word_t sub;
  aes_ke_pkg::word_t temp;

  always_comb begin
    rot  = {w_prev_i[23:0], w_prev_i[31:24]};
    sub  = {aes_ke_pkg::SBOX[rot[31:24]], aes_ke_pkg::SBOX[rot[23:16]],
            aes_ke_pkg::SBOX[rot[15:8]], aes_ke_pkg::SBOX[rot[7:0]]};
    temp = ctl_i.sub_en ? (sub ^ {ctl_i.rcon, 24'h000000}) : w_prev_i;
    w_new_o = w_back_i ^ temp;
  end

endmodule

// ===== hdl/aes_ke_seq.sv =====
// Sequencer: word counter, run flag and round constant.
module aes_ke_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        step_i,
  output logic                        busy_o,
  output logic [aes_ke_pkg::IdxW-1:0] idx_o,
  output logic                        last_o,
  output aes_ke_pkg::word_ctl_t       ctl_o
);

  logic                        busy_q, busy_d;
  logic [aes_ke_pkg::IdxW-1:0] idx_q, idx_d;
  logic [7:0]                  rcon_q, rcon_d;

  assign last_o = (idx_q == aes_ke_pkg::LastIdx);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    rcon_d = rcon_q;
    priority if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      rcon_d = aes_ke_pkg::RconFirst;
    end else if (step_i) begin
      busy_d = !last_o;
      idx_d  = idx_q + 1'b1;
      if (idx_q[1:0] == 2'b00) begin
        rcon_d = aes_ke_pkg::xtime(rcon_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      rcon_q <= aes_ke_pkg::RconFirst;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      rcon_q <= rcon_d;
    end
  end

  // word idx+4 takes the S-box path when idx is a multiple of four
  assign ctl_o.sub_en = (idx_q[1:0] == 2'b00);
  assign ctl_o.rcon   = rcon_q;
  assign busy_o       = busy_q;
  assign idx_o        = idx_q;

endmodule

// ===== hdl/aes128_key_expansion.sv =====
// AES-128 key expansion: one key request in, 44 schedule words out.
//
// key_i takes one request: the four cipher key columns, byte 0 in bits 31..24.
// word_o then delivers words 0 to 43 of the key schedule in order, one per
// handshake, tagged with word_index; last_word marks word 43.
// The first word is valid in the cycle after the key is accepted. Without
// stalls the block delivers one word per cycle: a four-word window shifts
// on each handshake and one shared word unit (four S-box lookups, Rcon, XOR)
// computes the word four places ahead.
// key_i.ready is high while no run is active and in the cycle in which word 43
// is taken, so keys can follow back to back.
// When word_o.ready is low the current word holds and the window does not move.
// Reset clears the run; word_o.valid is low and key_i.ready high afterward.
module aes128_key_expansion (
  input  logic          clk_i,
  input  logic          rst_ni,
  aes_ke_key_if.sink    key_i,
  aes_ke_word_if.source word_o
);

  logic                        busy;
  logic                        last;
  logic                        key_acc;
  logic                        word_acc;
  logic [aes_ke_pkg::IdxW-1:0] idx;
  aes_ke_pkg::word_ctl_t       ctl;
  aes_ke_pkg::word_t           w_new;
  aes_ke_pkg::word_t           win_q [4];

  assign word_acc    = word_o.valid && word_o.ready;
  assign key_i.ready = !busy || (word_acc && last);
  assign key_acc     = key_i.valid && key_i.ready;

  aes_ke_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(key_acc),
    .step_i (word_acc),
    .busy_o (busy),
    .idx_o  (idx),
    .last_o (last),
    .ctl_o  (ctl)
  );

  aes_ke_word_unit u_word (
    .w_back_i(win_q[0]),
    .w_prev_i(win_q[3]),
    .ctl_i   (ctl),
    .w_new_o (w_new)
  );

  always_ff @(posedge clk_i) begin
    if (key_acc) begin
      win_q[0] <= key_i.key_word_0;
      win_q[1] <= key_i.key_word_1;
      win_q[2] <= key_i.key_word_2;
      win_q[3] <= key_i.key_word_3;
    end else if (word_acc) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= w_new;
    end
  end

  assign word_o.valid         = busy;
  assign word_o.word_index    = idx;
  assign word_o.schedule_word = win_q[0];
  assign word_o.last_word     = last;

  a_start_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_acc |=> word_o.valid && (word_o.word_index == '0))
    else $error("run does not start at word 0");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_acc && !word_o.last_word && !key_acc) |=>
      (word_o.word_index == $past(word_o.word_index) + 1'b1))
    else $error("word index did not advance");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_acc && word_o.last_word && !key_acc) |=> !word_o.valid)
    else $error("run continues past word 43");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_o.valid && !(word_acc && word_o.last_word)) |-> !key_i.ready)
    else $error("key request taken during a run");

endmodule
